// ----- rtl/lome_pkg.sv -----
`timescale 1ns / 1ps
// Package for the linked order move engine: item structs, operation codes
// and defaults. No dependencies.
package lome_pkg;

  localparam int BALL_W          = 11;
  localparam int MAX_BALLS_DEF   = 1024;
  localparam logic [BALL_W-1:0] BALL_COUNT_RST = 11'd1024;

  typedef enum logic [1:0] {
    OP_RESTART    = 2'd0,
    OP_MOVE_LEFT  = 2'd1,
    OP_MOVE_RIGHT = 2'd2,
    OP_READ_NEXT  = 2'd3
  } op_t;

  typedef struct packed {
    op_t               operation;
    logic [BALL_W-1:0] moving_ball;
    logic [BALL_W-1:0] target_ball;
  } in_item_t;

  typedef struct packed {
    logic [BALL_W-1:0] next_ball;
    logic              at_end;
    logic              error;
  } out_item_t;

endpackage

// ----- rtl/linked_order_move_engine.sv -----
`timescale 1ns / 1ps
// Linked order move engine top level: doubly linked ball list in two link memories.
// Depends on lome_pkg and lome_link_ram.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | lome_pkg::in_item_t
//   out_    | output    | out_valid/out_stall| lome_pkg::out_item_t
//   cfg_    | input     | cfg_valid/cfg_ready| ball_count, 11 bits
//
// Each link memory has one read and one write port, so a move reads the moving
// ball's links, then unlinks it while reading the target's (S_MOVE_Y), then writes
// the relinks (S_MOVE_J1, S_MOVE_J2); a rejected move or read is answered from S_IDLE.
// After reset a clearing pass over all MAX_BALLS+2 slots rebuilds the links; items
// wait during it, configuration writes are taken.
// A stalled output holds its result; the next item is still taken, and its
// result waits in a hold register until the output frees.
module linked_order_move_engine #(
  parameter int MAX_BALLS = lome_pkg::MAX_BALLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lome_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lome_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lome_pkg::BALL_W-1:0]     cfg_data
);

  localparam int SLOTS = MAX_BALLS + 2;
  localparam int LW    = $clog2(SLOTS);
  localparam int NW    = ((LW > lome_pkg::BALL_W) ? LW : lome_pkg::BALL_W) + 1;
  localparam logic [LW-1:0] LAST_SLOT = LW'(MAX_BALLS + 1);
  localparam logic [NW-1:0] MAX_N     = NW'(MAX_BALLS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RESTART, S_MOVE_Y, S_MOVE_J1, S_MOVE_J2, S_READ, S_HOLD
  } state_t;

  state_t                      st_r, st_nxt;
  lome_pkg::op_t               op_r, op_nxt;
  logic [LW-1:0]               x_r, x_nxt, y_r, y_nxt;
  logic [LW-1:0]               l_r, l_nxt, r_r, r_nxt;
  logic [LW-1:0]               cnt_r, cnt_nxt;
  lome_pkg::out_item_t         hold_r, hold_nxt;
  lome_pkg::out_item_t         out_data_r, out_data_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [lome_pkg::BALL_W-1:0] ball_count_r;

  logic          rr_we, lr_we;
  logic [LW-1:0] rr_wa, rr_wd, lr_wa, lr_wd;
  logic [LW-1:0] rd_addr, rd_right, rd_left;

  logic [NW-1:0] n_w, x_w, y_w, nxt_w;
  logic [LW-1:0] in_x_a, in_y_a, ly, ry;
  logic          move_ok, read_ok, out_free, fin;
  lome_pkg::out_item_t fin_res;

  lome_link_ram #(.DEPTH(SLOTS), .AW(LW), .DW(LW)) u_right (
    .clk(clk), .we(rr_we), .waddr(rr_wa), .wdata(rr_wd),
    .raddr(rd_addr), .rdata(rd_right)
  );

  lome_link_ram #(.DEPTH(SLOTS), .AW(LW), .DW(LW)) u_left (
    .clk(clk), .we(lr_we), .waddr(lr_wa), .wdata(lr_wd),
    .raddr(rd_addr), .rdata(rd_left)
  );

  // effective count saturates at capacity
  assign n_w = (NW'(ball_count_r) > MAX_N) ? MAX_N : NW'(ball_count_r);
  assign x_w = NW'(in_data.moving_ball);
  assign y_w = NW'(in_data.target_ball);
  assign in_x_a = x_w[LW-1:0];
  assign in_y_a = y_w[LW-1:0];

  assign move_ok = (x_w != y_w) && (x_w != '0) && (x_w <= n_w)
                   && (y_w != '0) && (y_w <= n_w);
  assign read_ok = (x_w <= n_w);

  // neighbors of the target after the unlink of the moving ball
  assign ly = (y_r == r_r) ? l_r : rd_left;
  assign ry = (y_r == l_r) ? r_r : rd_right;
  assign nxt_w = NW'(rd_right);

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (st_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    st_nxt        = st_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    cnt_nxt       = cnt_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rr_we   = 1'b0;
    rr_wa   = '0;
    rr_wd   = '0;
    lr_we   = 1'b0;
    lr_wa   = '0;
    lr_wd   = '0;
    rd_addr = x_r;
    fin     = 1'b0;
    fin_res = '0;

    case (st_r)
      S_CLEAR: begin
        rr_we = 1'b1;
        rr_wa = cnt_r;
        rr_wd = cnt_r + LW'(1);
        lr_we = 1'b1;
        lr_wa = cnt_r;
        lr_wd = (cnt_r == '0) ? '0 : cnt_r - LW'(1);
        if (cnt_r == LAST_SLOT) begin
          st_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + LW'(1);
        end
      end
      S_IDLE: begin
        rd_addr = in_x_a;
        if (in_valid) begin
          op_nxt = in_data.operation;
          x_nxt  = in_x_a;
          y_nxt  = in_y_a;
          case (in_data.operation)
            lome_pkg::OP_RESTART: begin
              cnt_nxt = '0;
              st_nxt  = S_RESTART;
            end
            lome_pkg::OP_MOVE_LEFT, lome_pkg::OP_MOVE_RIGHT: begin
              if (move_ok) begin
                st_nxt = S_MOVE_Y;
              end else begin
                fin           = 1'b1;
                fin_res.error = 1'b1;
              end
            end
            lome_pkg::OP_READ_NEXT: begin
              if (read_ok) begin
                st_nxt = S_READ;
              end else begin
                fin           = 1'b1;
                fin_res.error = 1'b1;
              end
            end
            default: begin
              fin           = 1'b1;
              fin_res.error = 1'b1;
            end
          endcase
        end
      end
      S_RESTART: begin
        rr_we = 1'b1;
        rr_wa = cnt_r;
        rr_wd = cnt_r + LW'(1);
        lr_we = 1'b1;
        lr_wa = cnt_r + LW'(1);
        lr_wd = cnt_r;
        if (NW'(cnt_r) == n_w) begin
          fin = 1'b1;
        end else begin
          cnt_nxt = cnt_r + LW'(1);
        end
      end
      S_MOVE_Y: begin
        // unlink the moving ball, read the target's links
        l_nxt   = rd_left;
        r_nxt   = rd_right;
        rd_addr = y_r;
        rr_we   = 1'b1;
        rr_wa   = rd_left;
        rr_wd   = rd_right;
        lr_we   = 1'b1;
        lr_wa   = rd_right;
        lr_wd   = rd_left;
        st_nxt  = S_MOVE_J1;
      end
      S_MOVE_J1: begin
        rr_we = 1'b1;
        lr_we = 1'b1;
        if (op_r == lome_pkg::OP_MOVE_LEFT) begin
          rr_wa = ly;
          rr_wd = x_r;
          lr_wa = x_r;
          lr_wd = ly;
        end else begin
          rr_wa = x_r;
          rr_wd = ry;
          lr_wa = ry;
          lr_wd = x_r;
        end
        st_nxt = S_MOVE_J2;
      end
      S_MOVE_J2: begin
        rr_we = 1'b1;
        lr_we = 1'b1;
        if (op_r == lome_pkg::OP_MOVE_LEFT) begin
          rr_wa = x_r;
          rr_wd = y_r;
          lr_wa = y_r;
          lr_wd = x_r;
        end else begin
          rr_wa = y_r;
          rr_wd = x_r;
          lr_wa = x_r;
          lr_wd = y_r;
        end
        fin = 1'b1;
      end
      S_READ: begin
        fin               = 1'b1;
        fin_res.next_ball = nxt_w[lome_pkg::BALL_W-1:0];
        fin_res.at_end    = (nxt_w == n_w + NW'(1));
      end
      S_HOLD: begin
        fin     = 1'b1;
        fin_res = hold_r;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    // hand the result to the output register, or park it
    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = fin_res;
        st_nxt        = S_IDLE;
      end else begin
        hold_nxt = fin_res;
        st_nxt   = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_CLEAR;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      ball_count_r <= lome_pkg::BALL_COUNT_RST;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        ball_count_r <= cfg_data;
      end
    end
    op_r       <= op_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLEAR) |-> in_stall)
    else $error("item taken during clearing pass");

  a_link_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rr_we || lr_we) |-> (rr_wa <= LAST_SLOT && lr_wa <= LAST_SLOT))
    else $error("link write beyond last slot");

  a_error_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error) |-> (out_data.next_ball == '0 && !out_data.at_end))
    else $error("error result carries a successor");

  a_hold_keeps_output_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_HOLD) |-> out_valid_r)
    else $error("result parked while output register empty");

endmodule

// ----- rtl/lome_link_ram.sv -----
`timescale 1ns / 1ps
// Link memory: one write port, one read port, registered read data.
// Standalone; used twice by linked_order_move_engine.
module lome_link_ram #(
  parameter int DEPTH = 1026,
  parameter int AW    = 11,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // read returns the old contents when the same entry is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- dv/linked_order_move_engine_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for linked_order_move_engine: a directed table, then random
// phases over several ball counts, each result checked against the table's expected values or a local link-list model.
// Depends on lome_pkg and the engine RTL.
module linked_order_move_engine_tb;

  localparam int BW          = lome_pkg::BALL_W;
  localparam int MAX_BALLS   = lome_pkg::MAX_BALLS_DEF;
  localparam int SLOTS       = MAX_BALLS + 2;
  localparam int SW          = $clog2(SLOTS);
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYC  = 32;
  localparam int LIMIT_NS    = 4_000_000;

  typedef struct packed {
    logic              has_exp;
    lome_pkg::op_t     op;
    logic [BW-1:0]     moving;
    logic [BW-1:0]     target;
    logic [BW-1:0]     next_ball;
    logic              at_end;
    logic              error;
  } dir_row_t;

  typedef struct packed {
    logic [BW-1:0]     count;
    logic [15:0]       items;
    logic [6:0]        snd_pct;
    logic [6:0]        rcv_pct;
    logic              restart_first;
    logic              hold_off;
  } phase_t;

  localparam int DIR_ROWS = 25;
  // The list starts as 1..1024 in order after reset.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{1'b1, lome_pkg::OP_READ_NEXT,  11'd0,    11'd2047, 11'd1,    1'b0, 1'b0},
    '{1'b1, lome_pkg::OP_READ_NEXT,  11'd1024, 11'd0,    11'd1025, 1'b1, 1'b0},
    '{1'b1, lome_pkg::OP_READ_NEXT,  11'd1025, 11'd5,    11'd0,    1'b0, 1'b1},
    '{1'b1, lome_pkg::OP_READ_NEXT,  11'd2047, 11'd2047, 11'd0,    1'b0, 1'b1},
    '{1'b1, lome_pkg::OP_MOVE_LEFT,  11'd7,    11'd7,    11'd0,    1'b0, 1'b1},
    '{1'b1, lome_pkg::OP_MOVE_RIGHT, 11'd2047, 11'd2047, 11'd0,    1'b0, 1'b1},
    '{1'b1, lome_pkg::OP_MOVE_LEFT,  11'd0,    11'd5,    11'd0,    1'b0, 1'b1},
    '{1'b1, lome_pkg::OP_MOVE_RIGHT, 11'd1025, 11'd5,    11'd0,    1'b0, 1'b1},
    '{1'b1, lome_pkg::OP_MOVE_LEFT,  11'd5,    11'd0,    11'd0,    1'b0, 1'b1},
    '{1'b1, lome_pkg::OP_MOVE_RIGHT, 11'd5,    11'd1025, 11'd0,    1'b0, 1'b1},
    '{1'b1, lome_pkg::OP_MOVE_LEFT,  11'd3,    11'd2047, 11'd0,    1'b0, 1'b1},
    '{1'b0, lome_pkg::OP_MOVE_RIGHT, 11'd1,    11'd1024, 11'd0,    1'b0, 1'b0},
    '{1'b0, lome_pkg::OP_READ_NEXT,  11'd0,    11'd0,    11'd0,    1'b0, 1'b0},
    '{1'b0, lome_pkg::OP_READ_NEXT,  11'd1024, 11'd1,    11'd0,    1'b0, 1'b0},
    '{1'b0, lome_pkg::OP_READ_NEXT,  11'd1,    11'd2047, 11'd0,    1'b0, 1'b0},
    '{1'b0, lome_pkg::OP_MOVE_LEFT,  11'd1024, 11'd2,    11'd0,    1'b0, 1'b0},
    '{1'b0, lome_pkg::OP_READ_NEXT,  11'd0,    11'd0,    11'd0,    1'b0, 1'b0},
    '{1'b0, lome_pkg::OP_MOVE_RIGHT, 11'd500,  11'd501,  11'd0,    1'b0, 1'b0},
    '{1'b0, lome_pkg::OP_MOVE_LEFT,  11'd502,  11'd501,  11'd0,    1'b0, 1'b0},
    '{1'b0, lome_pkg::OP_MOVE_LEFT,  11'd501,  11'd500,  11'd0,    1'b0, 1'b0},
    '{1'b0, lome_pkg::OP_READ_NEXT,  11'd499,  11'd0,    11'd0,    1'b0, 1'b0},
    '{1'b0, lome_pkg::OP_READ_NEXT,  11'd500,  11'd0,    11'd0,    1'b0, 1'b0},
    '{1'b1, lome_pkg::OP_RESTART,    11'd2047, 11'd2047, 11'd0,    1'b0, 1'b0},
    '{1'b1, lome_pkg::OP_READ_NEXT,  11'd0,    11'd0,    11'd1,    1'b0, 1'b0},
    '{1'b1, lome_pkg::OP_READ_NEXT,  11'd1,    11'd2047, 11'd2,    1'b0, 1'b0}
  };

  localparam int PHASES = 10;
  // Counts of 2047 saturate to capacity; 1 and 0 leave no legal move.
  localparam phase_t PHASE_TABLE [PHASES] = '{
    '{11'd8,    16'd250, 7'd26, 7'd62, 1'b1, 1'b1},
    '{11'd2,    16'd100, 7'd26, 7'd62, 1'b1, 1'b0},
    '{11'd1024, 16'd150, 7'd26, 7'd62, 1'b0, 1'b0},
    '{11'd40,   16'd250, 7'd62, 7'd26, 1'b1, 1'b0},
    '{11'd12,   16'd120, 7'd62, 7'd26, 1'b0, 1'b1},
    '{11'd2047, 16'd50,  7'd62, 7'd26, 1'b0, 1'b0},
    '{11'd1,    16'd40,  7'd0,  7'd0,  1'b1, 1'b0},
    '{11'd0,    16'd40,  7'd0,  7'd0,  1'b0, 1'b0},
    '{11'd20,   16'd300, 7'd0,  7'd0,  1'b1, 1'b0},
    '{11'd300,  16'd150, 7'd0,  7'd0,  1'b1, 1'b0}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  lome_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  lome_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [BW-1:0]       cfg_data;

  // Model state: link memories and the ball count register
  logic [BW-1:0] right_of [SLOTS];
  logic [BW-1:0] left_of  [SLOTS];
  logic [BW-1:0] ball_count_q;

  lome_pkg::out_item_t pending_results [$];
  int        mismatch_cnt = 0;
  int        snd_idle_pct = 26;
  int        rcv_idle_pct = 62;
  int        hold_req_cnt = 0;

  linked_order_move_engine #(
    .MAX_BALLS (MAX_BALLS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int slot_of(input int i);
    return (i < SLOTS) ? i : 0;
  endfunction

  task automatic link_pair(input int a, input int b);
    right_of[SW'(slot_of(a))] = b[BW-1:0];
    left_of[SW'(slot_of(b))]  = a[BW-1:0];
  endtask

  // Apply one item to the model links and return the result it should produce.
  task automatic apply_ball_item(input lome_pkg::in_item_t it,
                                 output lome_pkg::out_item_t res);
    int n, x, y, i;
    n = (int'(ball_count_q) > MAX_BALLS) ? MAX_BALLS : int'(ball_count_q);
    x = int'(it.moving_ball);
    y = int'(it.target_ball);
    res = '0;
    case (it.operation)
      lome_pkg::OP_RESTART: begin
        for (i = 0; i <= n; i++) link_pair(i, i + 1);
      end
      lome_pkg::OP_READ_NEXT: begin
        if (x > n) begin
          res.error = 1'b1;
        end else begin
          res.next_ball = right_of[SW'(x)];
          res.at_end    = (int'(right_of[SW'(x)]) == n + 1);
        end
      end
      default: begin
        if (x == y || x < 1 || x > n || y < 1 || y > n) begin
          res.error = 1'b1;
        end else begin
          link_pair(int'(left_of[SW'(x)]), int'(right_of[SW'(x)]));
          if (it.operation == lome_pkg::OP_MOVE_LEFT) begin
            link_pair(int'(left_of[SW'(y)]), x);
            link_pair(x, y);
          end else begin
            link_pair(x, int'(right_of[SW'(y)]));
            link_pair(y, x);
          end
        end
      end
    endcase
  endtask

  // Mostly legal moves and in-range reads; the rest is noise, rejected moves and restarts.
  function automatic lome_pkg::in_item_t random_ball_item(input int n);
    lome_pkg::in_item_t it;
    int r, x, y, restart_pct;
    restart_pct = (n <= 64) ? 3 : 1;
    r = $urandom_range(99);
    it.operation   = lome_pkg::op_t'($urandom_range(3));
    it.moving_ball = BW'($urandom_range(2047));
    it.target_ball = BW'($urandom_range(2047));
    if (r < 8) begin
      // keep the fully random fields
    end else if (r < 12) begin
      it.operation   = $urandom_range(1) ? lome_pkg::OP_MOVE_LEFT : lome_pkg::OP_MOVE_RIGHT;
      x              = $urandom_range(n + 1);
      it.moving_ball = x[BW-1:0];
      it.target_ball = x[BW-1:0];
    end else if (r < 12 + restart_pct) begin
      it.operation = lome_pkg::OP_RESTART;
    end else if (r < 45 || n < 2) begin
      it.operation   = lome_pkg::OP_READ_NEXT;
      x              = $urandom_range(n);
      it.moving_ball = x[BW-1:0];
    end else begin
      it.operation = $urandom_range(1) ? lome_pkg::OP_MOVE_LEFT : lome_pkg::OP_MOVE_RIGHT;
      x = $urandom_range(n, 1);
      y = $urandom_range(n - 1, 1);
      if (y >= x) y++;
      it.moving_ball = x[BW-1:0];
      it.target_ball = y[BW-1:0];
    end
    return it;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t ns", what, got, want, $time);
    mismatch_cnt++;
  endtask

  // Offer one item, hold it until taken, then log its expected result.
  task automatic offer_item(input lome_pkg::in_item_t it, input logic use_typed,
                            input lome_pkg::out_item_t typed);
    lome_pkg::out_item_t predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_ball_item(it, predicted);
    pending_results.push_back(use_typed ? typed : predicted);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_ball_count(input logic [BW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    ball_count_q = value;
  endtask

  initial begin : receiver
    int seen;
    seen      = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_cnt != seen) begin
        // long hold-off so the engine fills up and stalls its input
        seen      = hold_req_cnt;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    lome_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected item, next_ball", int'(out_data.next_ball), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.next_ball !== want.next_ball)
          flag_mismatch("next_ball", int'(out_data.next_ball), int'(want.next_ball));
        if (out_data.at_end !== want.at_end)
          flag_mismatch("at_end", int'(out_data.at_end), int'(want.at_end));
        if (out_data.error !== want.error)
          flag_mismatch("error", int'(out_data.error), int'(want.error));
      end
    end
  end

  initial begin : stimulus
    int p, k, n, i;
    lome_pkg::in_item_t  it;
    lome_pkg::out_item_t typed;
    for (i = 0; i < SLOTS; i++) begin
      right_of[SW'(i)] = BW'(i + 1);
      left_of[SW'(i)]  = (i == 0) ? '0 : BW'(i - 1);
    end
    ball_count_q = lome_pkg::BALL_COUNT_RST;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_ROWS; k++) begin
      it.operation    = DIR_TABLE[k].op;
      it.moving_ball  = DIR_TABLE[k].moving;
      it.target_ball  = DIR_TABLE[k].target;
      typed.next_ball = DIR_TABLE[k].next_ball;
      typed.at_end    = DIR_TABLE[k].at_end;
      typed.error     = DIR_TABLE[k].error;
      offer_item(it, DIR_TABLE[k].has_exp, typed);
    end

    for (p = 0; p < PHASES; p++) begin
      settle();
      snd_idle_pct = int'(PHASE_TABLE[p].snd_pct);
      rcv_idle_pct = int'(PHASE_TABLE[p].rcv_pct);
      write_ball_count(PHASE_TABLE[p].count);
      n = (int'(ball_count_q) > MAX_BALLS) ? MAX_BALLS : int'(ball_count_q);
      if (PHASE_TABLE[p].restart_first) begin
        it = '0;
        it.operation = lome_pkg::OP_RESTART;
        offer_item(it, 1'b0, '0);
      end
      for (k = 0; k < int'(PHASE_TABLE[p].items); k++) begin
        if (PHASE_TABLE[p].hold_off && k == int'(PHASE_TABLE[p].items) / 2) hold_req_cnt++;
        offer_item(random_ball_item(n), 1'b0, '0);
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
